@@ rtl/core/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the positional double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = 5;
  localparam int unsigned CMD_W  = 3;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [FILL_W-1:0] fill_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ       = 3'd4,
    CMD_INSERT     = 3'd5,
    CMD_REMOVE     = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LEFT  = 2'd1,
    CELL_RIGHT = 2'd2,
    CELL_LOAD  = 2'd3
  } cell_op_e;

endpackage

`default_nettype wire

@@ rtl/core/double_ended_queue_positional.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_positional
// Double-ended queue kept in logical order in a row of cells; push, pop,
// read, insert, remove at a position and clear.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid_i/in_stall_o command, position, count,
//                                             write_data, force_overwrite
//   out      source     out_valid_o/out_stall_i status, read_data, fill_count
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_data_i (capacity in use)
//
// Push, pop, read, insert and clear never hold the input busy.
// Remove of n elements stalls the input while the cell row shifts left by
// n places, one place per cycle (none when the run ends at the back).
// The result is registered; the input stalls while it waits and is stalled.
// Reset empties the queue and sets the capacity to the full depth.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_positional (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire deq_pkg::fill_t            cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [deq_pkg::CMD_W-1:0] command_i,
  input  wire deq_pkg::fill_t            position_i,
  input  wire deq_pkg::fill_t            count_i,
  input  wire deq_pkg::elem_t            write_data_i,
  input  wire logic                      force_overwrite_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           status_o,
  output deq_pkg::elem_t                 read_data_o,
  output deq_pkg::fill_t                 fill_count_o
);
  import deq_pkg::*;

  localparam fill_t DEPTH_F = FILL_W'(DEPTH);

  fill_t    cap_q, cap_d;
  fill_t    fill_q, fill_d;
  fill_t    rm_left_q, rm_left_d;
  fill_t    rm_pos_q, rm_pos_d;
  logic     out_valid_q, out_valid_d;
  logic     status_q;
  elem_t    rdata_q;
  fill_t    ofill_q;

  logic     busy;
  logic     in_acc;
  logic     cfg_acc;
  cmd_e     cmd;
  logic     reject;
  logic     rd_en;
  idx_t     rd_idx;
  logic     load_en;
  idx_t     load_idx;
  logic     shl_en;
  fill_t    shl_from;
  logic     shr_en;
  fill_t    shr_from;
  logic     rm_start;
  logic [FILL_W:0] pos_end;
  fill_t    kv;

  elem_t    cell_data [DEPTH];
  cell_op_e cell_op   [DEPTH];

  assign busy        = (rm_left_q != '0);
  assign in_stall_o  = busy || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !busy;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign cmd         = cmd_e'(command_i);
  assign pos_end     = {1'b0, position_i} + {1'b0, count_i};

  always_comb begin
    reject   = 1'b0;
    rd_en    = 1'b0;
    rd_idx   = '0;
    load_en  = 1'b0;
    load_idx = '0;
    shl_en   = 1'b0;
    shl_from = '0;
    shr_en   = 1'b0;
    shr_from = '0;
    rm_start = 1'b0;
    fill_d   = fill_q;
    if (in_acc) begin
      unique case (cmd)
        CMD_PUSH_FRONT: begin
          if (fill_q >= cap_q && !force_overwrite_i) begin
            reject = 1'b1;
          end else begin
            load_en = 1'b1;
            shr_en  = 1'b1;
            if (fill_q < cap_q) fill_d = fill_q + 1'b1;
          end
        end
        CMD_PUSH_BACK: begin
          if (fill_q >= cap_q) begin
            if (!force_overwrite_i) begin
              reject = 1'b1;
            end else begin
              shl_en   = 1'b1;
              load_en  = 1'b1;
              load_idx = IDX_W'(cap_q - 1'b1);
            end
          end else begin
            load_en  = 1'b1;
            load_idx = IDX_W'(fill_q);
            fill_d   = fill_q + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (fill_q == '0) begin
            reject = 1'b1;
          end else begin
            rd_en  = 1'b1;
            shl_en = 1'b1;
            fill_d = fill_q - 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (fill_q == '0) begin
            reject = 1'b1;
          end else begin
            rd_en  = 1'b1;
            rd_idx = IDX_W'(fill_q - 1'b1);
            fill_d = fill_q - 1'b1;
          end
        end
        CMD_READ: begin
          if (position_i >= fill_q) begin
            reject = 1'b1;
          end else begin
            rd_en  = 1'b1;
            rd_idx = IDX_W'(position_i);
          end
        end
        CMD_INSERT: begin
          if (position_i > fill_q || fill_q >= cap_q) begin
            reject = 1'b1;
          end else begin
            load_en  = 1'b1;
            load_idx = IDX_W'(position_i);
            shr_en   = 1'b1;
            shr_from = position_i;
            fill_d   = fill_q + 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (pos_end > {1'b0, fill_q}) begin
            reject = 1'b1;
          end else begin
            rm_start = (count_i != '0) && (pos_end != {1'b0, fill_q});
            fill_d   = fill_q - count_i;
          end
        end
        CMD_CLEAR: fill_d = '0;
        default:   reject = 1'b1;
      endcase
    end else if (busy) begin
      shl_en   = 1'b1;
      shl_from = rm_pos_q;
    end
    if (cfg_acc) fill_d = '0;
  end

  always_comb begin
    kv = '0;
    for (int k = 0; k < DEPTH; k++) begin
      kv = FILL_W'(k);
      if (load_en && IDX_W'(k) == load_idx) begin
        cell_op[k] = CELL_LOAD;
      end else if (shl_en && kv >= shl_from) begin
        cell_op[k] = CELL_RIGHT;
      end else if (shr_en && kv > shr_from) begin
        cell_op[k] = CELL_LEFT;
      end else begin
        cell_op[k] = CELL_HOLD;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    deq_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .left_i  ((g == 0) ? write_data_i : cell_data[(g == 0) ? 0 : g - 1]),
      .right_i ((g == DEPTH - 1) ? elem_t'('0) : cell_data[(g == DEPTH - 1) ? g : g + 1]),
      .wdata_i (write_data_i),
      .data_o  (cell_data[g])
    );
  end

  always_comb begin
    cap_d = cap_q;
    if (cfg_acc) begin
      priority if (cfg_data_i == '0) begin
        cap_d = FILL_W'(1);
      end else if (cfg_data_i > DEPTH_F) begin
        cap_d = DEPTH_F;
      end else begin
        cap_d = cfg_data_i;
      end
    end
  end

  always_comb begin
    rm_left_d = rm_left_q;
    rm_pos_d  = rm_pos_q;
    if (rm_start) begin
      rm_left_d = count_i;
      rm_pos_d  = position_i;
    end else if (busy) begin
      rm_left_d = rm_left_q - 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= DEPTH_F;
      fill_q      <= '0;
      rm_left_q   <= '0;
      rm_pos_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      fill_q      <= fill_d;
      rm_left_q   <= rm_left_d;
      rm_pos_q    <= rm_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= reject;
      rdata_q  <= rd_en ? cell_data[rd_idx] : '0;
      ofill_q  <= fill_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_data_o  = rdata_q;
  assign fill_count_o = ofill_q;

`ifndef SYNTHESIS
  a_fill_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cap_q)
    else $error("fill count above capacity");

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != '0) && (cap_q <= DEPTH_F))
    else $error("capacity out of range");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (in_stall_o && !cfg_ready_o))
    else $error("input or config taken during shift");

  a_out_from_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc))
    else $error("result without transaction");

  a_shift_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (rm_left_q == $past(rm_left_q) - 1'b1))
    else $error("shift counter skipped");
`endif

endmodule

`default_nettype wire

@@ rtl/core/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row: holds an element, takes its left or
// right neighbor's element, or loads new write data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell (
  input  wire logic                 clk_i,
  input  wire deq_pkg::cell_op_e    op_i,
  input  wire deq_pkg::elem_t       left_i,
  input  wire deq_pkg::elem_t       right_i,
  input  wire deq_pkg::elem_t       wdata_i,
  output deq_pkg::elem_t            data_o
);
  import deq_pkg::*;

  elem_t data_q, data_d;

  always_comb begin
    unique case (op_i)
      CELL_HOLD:  data_d = data_q;
      CELL_LEFT:  data_d = left_i;
      CELL_RIGHT: data_d = right_i;
      CELL_LOAD:  data_d = wdata_i;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire
